[rtl/core/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator: default
// geometry, field widths, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package ffba_pkg;

   // Default geometry of the managed storage
   localparam int NUM_BLOCKS_DEF      = 1024;
   localparam int RESERVED_BLOCKS_DEF = 4;

   // Fixed transaction field widths
   localparam int OP_W     = 2;
   localparam int CNT_W    = 11;
   localparam int START_W  = 10;
   localparam int REQ_W    = 24;   // block_count + start_block, padded to bytes
   localparam int RSP_W    = 16;   // status + run_start, padded to bytes

   // Operation codes carried in req_tuser
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_MARK  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

[rtl/core/ffba_ram.sv]
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/first_fit_block_allocator_core.sv]
// Alloc: a scan of the bitmap, then one write per block of the run it found;
//   free writes block_count blocks (count clipped at the last block); format rewrites the whole map.
// Throughput: one transaction at a time; the bitmap RAM, with one write and one read
//   port, is walked one block per cycle.
// Reset: synchronous, active high; afterwards a clearing pass rewrites the bitmap
//   while req_tready stays low.
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit contiguous allocator over a free/used bitmap held in RAM. One
// shared cursor and adder walk the bitmap for scan, mark and format passes.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core #(
   parameter int NUM_BLOCKS      = ffba_pkg::NUM_BLOCKS_DEF,
   parameter int RESERVED_BLOCKS = ffba_pkg::RESERVED_BLOCKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ffba_pkg::REQ_W-1:0]  req_tdata,  // [10:0] block_count, [20:11] start_block
   input  logic [ffba_pkg::OP_W-1:0]   req_tuser,  // [1:0] opcode
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ffba_pkg::RSP_W-1:0]  rsp_tdata   // [0] status, [10:1] run_start
);

   localparam int ADDR_W = $clog2(NUM_BLOCKS);
   localparam int CUR_W  = ADDR_W + 1;
   localparam int SUM_W  = ((CUR_W > ffba_pkg::CNT_W) ? CUR_W : ffba_pkg::CNT_W) + 1;

   localparam logic [CUR_W-1:0] CUR_NUM  = CUR_W'(NUM_BLOCKS);
   localparam logic [CUR_W-1:0] CUR_LAST = CUR_W'(NUM_BLOCKS - 1);
   localparam logic [CUR_W-1:0] CUR_RES  = CUR_W'(RESERVED_BLOCKS);
   localparam logic [SUM_W-1:0] SUM_NUM  = SUM_W'(NUM_BLOCKS);

   // Request fields
   logic [ffba_pkg::OP_W-1:0]    req_op;
   logic [ffba_pkg::CNT_W-1:0]   req_cnt;
   logic [ffba_pkg::START_W-1:0] req_start;

   assign req_op    = req_tuser;
   assign req_cnt   = req_tdata[10:0];
   assign req_start = req_tdata[20:11];

   // Sequencer and datapath registers
   ffba_pkg::state_type          state_ff, state_in;
   logic [CUR_W-1:0]             cur_ff, cur_in;
   logic [CUR_W-1:0]             end_ff, end_in;
   logic [CUR_W-1:0]             run_ff, run_in;
   logic [ADDR_W-1:0]            head_ff, head_in;
   logic [ffba_pkg::OP_W-1:0]    op_ff, op_in;
   logic [ffba_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         fill_ff, fill_in;
   logic                         fail_ff, fail_in;
   logic                         fmt_rsp_ff, fmt_rsp_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]            rd_addr_ff, rd_addr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_status_ff, rsp_status_in;
   logic [ffba_pkg::START_W-1:0] rsp_start_ff, rsp_start_in;

   // Bitmap RAM ports
   logic              wr_en, rd_en, wr_data, rd_data;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   // Shared adder results
   logic [SUM_W-1:0] start_ext, free_end, alloc_end, run_inc;
   logic             req_fire, bit_free, run_hit, rsp_free;

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ffba_pkg::ST_IDLE);
   assign bit_free  = rd_data;
   assign run_inc   = SUM_W'(run_ff) + SUM_W'(1);
   assign run_hit   = bit_free && (run_inc == SUM_W'(cnt_ff));
   assign start_ext = SUM_W'(req_start);
   assign free_end  = start_ext + SUM_W'(req_cnt);
   assign alloc_end = SUM_W'(head_in) + SUM_W'(cnt_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // Bitmap access: clear and mark write at the cursor, scan reads at it
   assign wr_en   = (state_ff == ffba_pkg::ST_CLEAR) ||
                    ((state_ff == ffba_pkg::ST_MARK) && (cur_ff != end_ff));
   assign wr_addr = cur_ff[ADDR_W-1:0];
   assign wr_data = (state_ff == ffba_pkg::ST_CLEAR) ? (cur_ff >= CUR_RES) : fill_ff;
   assign rd_en   = (state_ff == ffba_pkg::ST_SCAN) && (cur_ff != CUR_NUM);
   assign rd_addr = cur_ff[ADDR_W-1:0];

   ffba_ram #(
      .WIDTH (1),
      .DEPTH (NUM_BLOCKS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      end_in        = end_ff;
      run_in        = run_ff;
      head_in       = head_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      fill_in       = fill_ff;
      fail_in       = fail_ff;
      fmt_rsp_in    = fmt_rsp_ff;
      rd_vld_in     = rd_en;
      rd_addr_in    = cur_ff[ADDR_W-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;

      case (state_ff)
         // Rewrite the bitmap to its reset pattern, one block per cycle
         ffba_pkg::ST_CLEAR: begin
            cur_in = cur_ff + CUR_W'(1);
            if (cur_ff == CUR_LAST) begin
               fmt_rsp_in = 1'b0;
               state_in   = fmt_rsp_ff ? ffba_pkg::ST_DONE : ffba_pkg::ST_IDLE;
            end
         end

         // Take a transaction and set up the pass it needs
         ffba_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_op;
               cnt_in  = req_cnt;
               fail_in = 1'b0;
               cur_in  = '0;
               run_in  = '0;
               case (req_op)
                  ffba_pkg::OP_ALLOC: begin
                     if (req_cnt == '0) begin
                        fail_in  = 1'b1;
                        state_in = ffba_pkg::ST_DONE;
                     end else begin
                        state_in = ffba_pkg::ST_SCAN;
                     end
                  end
                  ffba_pkg::OP_FREE: begin
                     fill_in = 1'b1;
                     if (start_ext >= SUM_NUM) begin
                        state_in = ffba_pkg::ST_DONE;
                     end else begin
                        cur_in   = CUR_W'(start_ext);
                        end_in   = (free_end > SUM_NUM) ? CUR_NUM : CUR_W'(free_end);
                        state_in = ffba_pkg::ST_MARK;
                     end
                  end
                  ffba_pkg::OP_FORMAT: begin
                     fmt_rsp_in = 1'b1;
                     state_in   = ffba_pkg::ST_CLEAR;
                  end
                  default: begin
                     state_in = ffba_pkg::ST_DONE;
                  end
               endcase
            end
         end

         // Issue one read per cycle and track the current free run
         ffba_pkg::ST_SCAN: begin
            if (rd_en) begin
               cur_in = cur_ff + CUR_W'(1);
            end
            if (rd_vld_ff) begin
               run_in  = bit_free ? CUR_W'(run_inc) : '0;
               head_in = (bit_free && (run_ff == '0)) ? rd_addr_ff : head_ff;
            end
            if (rd_vld_ff && run_hit) begin
               fill_in  = 1'b0;
               cur_in   = CUR_W'(head_in);
               end_in   = CUR_W'(alloc_end);
               state_in = ffba_pkg::ST_MARK;
            end else if ((cur_ff == CUR_NUM) && !rd_vld_ff) begin
               fail_in  = 1'b1;
               state_in = ffba_pkg::ST_DONE;
            end
         end

         // Write the fill value over the range, one block per cycle
         ffba_pkg::ST_MARK: begin
            if (cur_ff == end_ff) begin
               state_in = ffba_pkg::ST_DONE;
            end else begin
               cur_in = cur_ff + CUR_W'(1);
            end
         end

         // Load the response register once it is free
         ffba_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fail_ff;
               rsp_start_in  = ((op_ff == ffba_pkg::OP_ALLOC) && !fail_ff) ?
                               ffba_pkg::START_W'(head_ff) : '0;
               state_in      = ffba_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ffba_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffba_pkg::ST_CLEAR;
         cur_ff       <= '0;
         fmt_rsp_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         fmt_rsp_ff   <= fmt_rsp_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      end_ff        <= end_in;
      run_ff        <= run_in;
      head_ff       <= head_in;
      op_ff         <= op_in;
      cnt_ff        <= cnt_in;
      fill_ff       <= fill_in;
      fail_ff       <= fail_in;
      rd_addr_ff    <= rd_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(ffba_pkg::RSP_W - ffba_pkg::START_W - 1)'(0), rsp_start_ff,
                        rsp_status_ff};

endmodule

[rtl/core/ffba_checker.sv]
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the allocator core, attached by bind.
// ----------------------------------------------------------------------------
module ffba_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [ffba_pkg::RSP_W-1:0] rsp_tdata
);

   // Hold a stalled response transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // A failed allocation reports block zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[10:1] == '0)
      else $error("failed allocation with nonzero run_start");

   // Drop ready for the cycle after a request transaction
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready high right after a request");

   // Clearing pass after reset: no ready, no response
   a_reset_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready && !rsp_tvalid)
      else $error("activity during post-reset clearing pass");

   // Padding bits of the response stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:11] == '0)
      else $error("response padding nonzero");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (.*);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for first_fit_block_allocator_core. A directed table
// covers the edge cases: empty and oversized requests, frees clipped at the
// top block, reserved blocks, format and the unused opcode. Random traffic
// then mixes allocations, frees of live runs, stray frees, formats and
// the unused opcode. The bench keeps its own copy of the free map to
// predict each response, and both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [ffba_pkg::OP_W-1:0] OP_ALLOC  = ffba_pkg::OP_ALLOC;
   localparam logic [ffba_pkg::OP_W-1:0] OP_FREE   = ffba_pkg::OP_FREE;
   localparam logic [ffba_pkg::OP_W-1:0] OP_FORMAT = ffba_pkg::OP_FORMAT;

   localparam int NB = ffba_pkg::NUM_BLOCKS_DEF;
   localparam int RB = ffba_pkg::RESERVED_BLOCKS_DEF;

   localparam logic [ffba_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic STAT_OK       = 1'b0;
   localparam logic STAT_NO_SPACE = 1'b1;
   localparam logic PINNED        = 1'b1;
   localparam logic PREDICTED     = 1'b0;

   localparam int DIRECTED_ROWS  = 25;
   localparam int RANDOM_ITEMS   = 265;
   localparam int DRAIN_AT       = 60;
   localparam int CALM_FIRST     = 120;
   localparam int CALM_LAST      = 180;
   localparam int IDLE_PCT       = 35;
   localparam int MAX_REPORTS    = 10;
   localparam int SETTLE_CYCLES  = 2 * NB + 16;
   localparam int WATCHDOG_LIMIT = 20000;

   // One request, plus an optional hand-typed response
   typedef struct packed {
      logic [ffba_pkg::OP_W-1:0]    op;
      logic [ffba_pkg::CNT_W-1:0]   cnt;
      logic [ffba_pkg::START_W-1:0] start;
      logic                         pinned;
      logic                         status;
      logic [ffba_pkg::START_W-1:0] first;
   } cmd_row_type;

   typedef struct packed {
      logic                         status;
      logic [ffba_pkg::START_W-1:0] first;
   } outcome_type;

   typedef struct packed {
      logic [ffba_pkg::START_W-1:0] first;
      logic [ffba_pkg::CNT_W-1:0]   len;
   } span_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [ffba_pkg::REQ_W-1:0]  req_tdata  = '0;  // [10:0] block_count, [20:11] start_block
   logic [ffba_pkg::OP_W-1:0]   req_tuser  = '0;  // [1:0] opcode
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [ffba_pkg::RSP_W-1:0]  rsp_tdata;        // [0] status, [10:1] run_start

   logic [NB-1:0] vacant_map;
   outcome_type   pending_outcomes[$];
   span_type      live_runs[$];
   cmd_row_type   pinned_row = '0;
   bit            calm = 1'b0;
   int            fault_count = 0;
   int            quiet_cycles = 0;

   first_fit_block_allocator_core #(
      .NUM_BLOCKS      (NB),
      .RESERVED_BLOCKS (RB)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Restore the power-on pattern: reserved blocks used, the rest free
   function automatic void format_vacancy();
      int b;
      for (b = 0; b < NB; b++) begin
         vacant_map[b] = (b >= RB);
      end
   endfunction

   // Apply one request to the shadow map and return the response it earns
   function automatic outcome_type judge_request(cmd_row_type row);
      outcome_type res;
      int          b;
      int          run;
      int          head;
      int          stop;
      bit          found;
      res   = '0;
      run   = 0;
      head  = 0;
      found = 1'b0;
      res.status = STAT_OK;
      case (row.op)
         OP_ALLOC: begin
            // first fit: a zero length never matches since run starts at one
            for (b = 0; b < NB && !found; b++) begin
               if (!vacant_map[b]) begin
                  run = 0;
               end else begin
                  if (run == 0) head = b;
                  run++;
                  if (run == int'(row.cnt)) found = 1'b1;
               end
            end
            if (found) begin
               stop = head + int'(row.cnt);
               for (b = head; b < stop; b++) vacant_map[b] = 1'b0;
               res.first = ffba_pkg::START_W'(head);
               live_runs.push_back('{first: ffba_pkg::START_W'(head), len: row.cnt});
            end else begin
               res.status = STAT_NO_SPACE;
            end
         end
         OP_FREE: begin
            // clip the range at the top block
            if (int'(row.start) < NB) begin
               stop = int'(row.start) + int'(row.cnt);
               if (stop > NB) stop = NB;
               for (b = int'(row.start); b < stop; b++) vacant_map[b] = 1'b1;
            end
         end
         OP_FORMAT: begin
            format_vacancy();
            live_runs.delete();
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic void report_fault(string what, int want, int got);
      if (fault_count < MAX_REPORTS) begin
         $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $time);
      end
      fault_count++;
   endfunction

   // Mostly short runs, now and then empty, medium or oversized
   function automatic logic [ffba_pkg::CNT_W-1:0] roll_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) return '0;
      else if (pick < 84) return ffba_pkg::CNT_W'($urandom_range(1, 16));
      else if (pick < 96) return ffba_pkg::CNT_W'($urandom_range(17, 128));
      else return ffba_pkg::CNT_W'($urandom_range(129, 2047));
   endfunction

   function automatic cmd_row_type roll_command();
      cmd_row_type row;
      span_type    span;
      int          pick;
      int          slot;
      row       = '0;
      row.start = ffba_pkg::START_W'($urandom_range(0, NB - 1));
      row.cnt   = roll_length();
      pick      = $urandom_range(0, 99);
      if (pick < 45) begin
         row.op = OP_ALLOC;
      end else if (pick < 85) begin
         row.op = OP_FREE;
         // release a live run most of the time, sometimes with a random length instead
         if (live_runs.size() != 0 && $urandom_range(0, 99) < 70) begin
            slot = $urandom_range(0, live_runs.size() - 1);
            span = live_runs[slot];
            live_runs.delete(slot);
            row.start = span.first;
            row.cnt   = ($urandom_range(0, 3) == 0) ?
                        ffba_pkg::CNT_W'($urandom_range(0, int'(span.len) + 2)) : span.len;
         end
      end else if (pick < 93) begin
         row.op = OP_FORMAT;
      end else begin
         row.op = OP_UNUSED;
      end
      return row;
   endfunction

   // Present one request, optionally after an idle gap, and hold it until taken
   task automatic issue(cmd_row_type row);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < IDLE_PCT);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.op;
      req_tdata  <= {3'b000, row.start, row.cnt};
      pinned_row  = row;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold off the sender until every response is back
   task automatic settle_out();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_outcomes.size() != 0);
   endtask

   // Randomly stall the response side
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Check responses against the oldest prediction, then log new requests
   always @(posedge clock) begin : scoreboard
      outcome_type want;
      cmd_row_type seen;
      if (reset) begin
         format_vacancy();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               report_fault("unexpected response, data", 0, int'(rsp_tdata));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_tdata[0] !== want.status)
                  report_fault("status", int'(want.status), int'(rsp_tdata[0]));
               if (rsp_tdata[10:1] !== want.first)
                  report_fault("run_start", int'(want.first), int'(rsp_tdata[10:1]));
            end
         end
         if (req_tvalid && req_tready) begin
            seen        = pinned_row;
            seen.op     = req_tuser;
            seen.cnt    = req_tdata[10:0];
            seen.start  = req_tdata[20:11];
            want        = judge_request(seen);
            if (seen.pinned) want = '{status: seen.status, first: seen.first};
            pending_outcomes.push_back(want);
         end
      end
   end

   // Abort when nothing moves for far longer than the slowest transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      cmd_row_type directed_plan [DIRECTED_ROWS];
      directed_plan = '{
         // op        count     start     check      status         run_start
         '{OP_ALLOC,  11'd1,    10'd0,    PINNED,    STAT_OK,       10'd4},
         '{OP_ALLOC,  11'd0,    10'd0,    PINNED,    STAT_NO_SPACE, 10'd0},
         '{OP_ALLOC,  11'd1025, 10'd1023, PINNED,    STAT_NO_SPACE, 10'd0},
         '{OP_ALLOC,  11'd2047, 10'd0,    PINNED,    STAT_NO_SPACE, 10'd0},
         '{OP_ALLOC,  11'd1019, 10'd0,    PREDICTED, STAT_OK,       10'd0},
         '{OP_ALLOC,  11'd1,    10'd0,    PREDICTED, STAT_OK,       10'd0},
         '{OP_FREE,   11'd2047, 10'd1023, PINNED,    STAT_OK,       10'd0},
         '{OP_FREE,   11'd0,    10'd0,    PINNED,    STAT_OK,       10'd0},
         '{OP_FREE,   11'd2,    10'd0,    PINNED,    STAT_OK,       10'd0},
         '{OP_ALLOC,  11'd2,    10'd0,    PREDICTED, STAT_OK,       10'd0},
         '{OP_ALLOC,  11'd1,    10'd0,    PREDICTED, STAT_OK,       10'd0},
         '{OP_FORMAT, 11'd0,    10'd0,    PINNED,    STAT_OK,       10'd0},
         '{OP_UNUSED, 11'd1024, 10'd1023, PINNED,    STAT_OK,       10'd0},
         '{OP_ALLOC,  11'd1020, 10'd0,    PINNED,    STAT_OK,       10'd4},
         '{OP_FREE,   11'd1,    10'd4,    PINNED,    STAT_OK,       10'd0},
         '{OP_FREE,   11'd2,    10'd6,    PINNED,    STAT_OK,       10'd0},
         '{OP_ALLOC,  11'd2,    10'd0,    PREDICTED, STAT_OK,       10'd0},
         '{OP_ALLOC,  11'd1,    10'd0,    PREDICTED, STAT_OK,       10'd0},
         '{OP_FREE,   11'd1024, 10'd512,  PINNED,    STAT_OK,       10'd0},
         '{OP_ALLOC,  11'd512,  10'd0,    PREDICTED, STAT_OK,       10'd0},
         '{OP_FORMAT, 11'd2047, 10'd1023, PINNED,    STAT_OK,       10'd0},
         '{OP_ALLOC,  11'd1024, 10'd0,    PREDICTED, STAT_OK,       10'd0},
         '{OP_FREE,   11'd4,    10'd0,    PINNED,    STAT_OK,       10'd0},
         '{OP_ALLOC,  11'd1024, 10'd0,    PREDICTED, STAT_OK,       10'd0},
         '{OP_FORMAT, 11'd0,    10'd0,    PINNED,    STAT_OK,       10'd0}
      };

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // walk the directed table
      foreach (directed_plan[i]) issue(directed_plan[i]);
      settle_out();

      // random traffic, with one drained pause and one stretch without stalls
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= CALM_FIRST && n < CALM_LAST);
         if (n == DRAIN_AT) settle_out();
         issue(roll_command());
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // let the last responses land, then watch for strays
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/ffba_pkg.sv
rtl/core/ffba_ram.sv
rtl/core/first_fit_block_allocator_core.sv
rtl/core/ffba_checker.sv
sim/tb.sv
